// ===== rtl/tcklru_pkg.sv =====
// types, constants and helpers shared by the two-character-key lru cache
// no dependencies; used by tcklru_ram users and the top level
`default_nettype none

package tcklru_pkg;

	// result status codes
	localparam logic [2:0] STATUS_BAD_KEY   = 3'd0;
	localparam logic [2:0] STATUS_HIT       = 3'd1;
	localparam logic [2:0] STATUS_MISS      = 3'd2;
	localparam logic [2:0] STATUS_INSTALLED = 3'd3;
	localparam logic [2:0] STATUS_SIZE_REJ  = 3'd4;

	// request kinds
	localparam logic KIND_LOOKUP  = 1'b0;
	localparam logic KIND_INSTALL = 1'b1;

	// configuration register indexes (word address bit 2)
	localparam logic REG_MAX_ITEM = 1'b0;

	localparam logic [15:0] MAX_ITEM_RESET = 16'd8192;
	localparam logic [31:0] STAMP_CEILING  = 32'hFFFF_FFFF;
	localparam int          SLOT_W         = 5;

	typedef struct packed {
		logic        kind;
		logic [7:0]  key_first;
		logic [7:0]  key_second;
		logic        key_length_ok;
		logic [15:0] item_size;
		logic [31:0] buffer_handle;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       entry_handle;
		logic [15:0]       entry_size;
		logic              evicted;
		logic [31:0]       evicted_handle;
	} result_t;

	// one cache entry as held in the entry memory
	typedef struct packed {
		logic [15:0] key;
		logic [31:0] stamp;
		logic [31:0] handle;
		logic [15:0] bytes;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// ascii upper case letters become lower case, all else passes
	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/two_char_key_lru_cache_top.sv =====
// two-character-key fully associative cache with timestamp lru replacement
// depends on tcklru_pkg and tcklru_ram
// bad key and size reject answer in the cycle after start; lookups and installs
// scan the entry ram one entry a cycle.
// one transaction at a time, next start taken in the result cycle; results cannot stall
// reset clears valid bits, the use tick and max_item_bytes (8192); the entry ram is not cleared.
`default_nettype none

module two_char_key_lru_cache_top #(
	parameter int ENTRIES = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// command channel
	input  wire logic               start,
	output logic                    busy,
	input  wire tcklru_pkg::cmd_t   cmd,
	// result channel
	output logic                    done,
	output tcklru_pkg::result_t     result,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                       state_q;
	logic                       kind_q;
	logic [15:0]                key_q;
	logic [15:0]                size_q;
	logic [31:0]                handle_q;
	logic [31:0]                tick_q;
	logic [ENTRIES-1:0]         valid_q;
	logic [15:0]                max_q;
	logic [IDX_W-1:0]           rd_idx_q;
	logic                       rd_on_q;
	logic                       chk_vld_s1;
	logic [IDX_W-1:0]           chk_idx_s1;
	logic [IDX_W-1:0]           best_slot_q;
	logic [31:0]                best_stamp_q;
	logic [31:0]                best_handle_q;
	logic                       done_q;
	tcklru_pkg::result_t        res_q;

	logic                       accept;
	logic                       cfg_wr;
	logic                       size_bad;
	logic                       refuse;
	tcklru_pkg::result_t        early_res;
	tcklru_pkg::entry_t         ent;
	logic [tcklru_pkg::ENTRY_W-1:0] rdata;
	logic                       ent_valid;
	logic                       chk_last;
	logic                       hit;
	logic [31:0]                cur_stamp;
	logic [IDX_W-1:0]           cur_slot;
	logic [31:0]                cur_handle;
	logic                       older;
	logic [IDX_W-1:0]           nxt_slot;
	logic [31:0]                nxt_stamp;
	logic [31:0]                nxt_handle;
	logic                       fin;
	tcklru_pkg::result_t        fin_res;
	logic                       we;
	logic [IDX_W-1:0]           waddr;
	tcklru_pkg::entry_t         wentry;

	// index to the 5-bit slot field, zero extended or truncated
	function automatic logic [tcklru_pkg::SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
		logic [tcklru_pkg::SLOT_W+IDX_W-1:0] wide;
		wide = {{tcklru_pkg::SLOT_W{1'b0}}, idx};
		return wide[tcklru_pkg::SLOT_W-1:0];
	endfunction

	assign accept   = start && !busy;
	assign busy     = (state_q == ST_SCAN);
	assign done     = done_q;
	assign result   = res_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign size_bad = (cmd.item_size == 16'd0) || (cmd.item_size > max_q);
	assign refuse   = !cmd.key_length_ok || (cmd.kind == tcklru_pkg::KIND_INSTALL && size_bad);

	// immediate result for a refused command
	always_comb begin
		early_res = '0;
		if (!cmd.key_length_ok) begin
			early_res.status = tcklru_pkg::STATUS_BAD_KEY;
		end else begin
			early_res.status = tcklru_pkg::STATUS_SIZE_REJ;
		end
	end

	// register read back
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == tcklru_pkg::REG_MAX_ITEM) begin
			prdata = {16'd0, max_q};
		end
	end

	// entry memory
	tcklru_ram #(
		.WIDTH (tcklru_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wentry),
		.re    (rd_on_q),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	assign ent       = tcklru_pkg::entry_t'(rdata);
	assign ent_valid = valid_q[chk_idx_s1];
	assign chk_last  = (chk_idx_s1 == LAST_IDX);
	assign hit       = ent_valid && (ent.key == key_q);

	// running oldest candidate; slot 0 is the default victim
	always_comb begin
		if (chk_idx_s1 == '0) begin
			cur_stamp  = tcklru_pkg::STAMP_CEILING;
			cur_slot   = '0;
			cur_handle = ent.handle;
		end else begin
			cur_stamp  = best_stamp_q;
			cur_slot   = best_slot_q;
			cur_handle = best_handle_q;
		end
		older = ent.stamp < cur_stamp;
		if (older) begin
			nxt_slot   = chk_idx_s1;
			nxt_stamp  = ent.stamp;
			nxt_handle = ent.handle;
		end else begin
			nxt_slot   = cur_slot;
			nxt_stamp  = cur_stamp;
			nxt_handle = cur_handle;
		end
	end

	// scan decision for the entry that just came out of the ram
	always_comb begin
		fin     = 1'b0;
		fin_res = '0;
		we      = 1'b0;
		waddr   = chk_idx_s1;
		wentry  = '{key: key_q, stamp: tick_q, handle: handle_q, bytes: size_q};
		if (state_q == ST_SCAN && chk_vld_s1) begin
			unique case (kind_q)
				tcklru_pkg::KIND_LOOKUP: begin
					if (hit) begin
						fin                  = 1'b1;
						we                   = 1'b1;
						wentry               = '{key: ent.key, stamp: tick_q,
							handle: ent.handle, bytes: ent.bytes};
						fin_res.status       = tcklru_pkg::STATUS_HIT;
						fin_res.slot         = to_slot(chk_idx_s1);
						fin_res.entry_handle = ent.handle;
						fin_res.entry_size   = ent.bytes;
					end else if (chk_last) begin
						fin            = 1'b1;
						fin_res.status = tcklru_pkg::STATUS_MISS;
					end
				end
				tcklru_pkg::KIND_INSTALL: begin
					if (!ent_valid || chk_last) begin
						fin                  = 1'b1;
						we                   = 1'b1;
						fin_res.status       = tcklru_pkg::STATUS_INSTALLED;
						fin_res.entry_handle = handle_q;
						fin_res.entry_size   = size_q;
						if (!ent_valid) begin
							waddr        = chk_idx_s1;
							fin_res.slot = to_slot(chk_idx_s1);
						end else begin
							waddr                  = nxt_slot;
							fin_res.slot           = to_slot(nxt_slot);
							fin_res.evicted        = 1'b1;
							fin_res.evicted_handle = nxt_handle;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= tcklru_pkg::MAX_ITEM_RESET;
		end else if (cfg_wr && paddr[2] == tcklru_pkg::REG_MAX_ITEM) begin
			max_q <= pwdata[15:0];
		end
	end

	// control: accept, scan, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tick_q     <= '0;
			valid_q    <= '0;
			rd_idx_q   <= '0;
			rd_on_q    <= 1'b0;
			chk_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= accept && refuse;
					if (accept && !refuse) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
						rd_on_q  <= 1'b1;
						if (cmd.kind == tcklru_pkg::KIND_LOOKUP) begin
							tick_q <= tick_q + 32'd1;
						end
					end
				end
				ST_SCAN: begin
					done_q <= fin;
					if (fin) begin
						state_q    <= ST_IDLE;
						rd_on_q    <= 1'b0;
						chk_vld_s1 <= 1'b0;
						if (kind_q == tcklru_pkg::KIND_INSTALL) begin
							valid_q[waddr] <= 1'b1;
						end
					end else begin
						chk_vld_s1 <= rd_on_q;
						if (rd_on_q) begin
							if (rd_idx_q == LAST_IDX) begin
								rd_on_q <= 1'b0;
							end else begin
								rd_idx_q <= rd_idx_q + IDX_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			kind_q   <= cmd.kind;
			key_q    <= {tcklru_pkg::fold_case(cmd.key_first),
				tcklru_pkg::fold_case(cmd.key_second)};
			size_q   <= cmd.item_size;
			handle_q <= cmd.buffer_handle;
			res_q    <= early_res;
		end
		if (state_q == ST_SCAN && chk_vld_s1) begin
			chk_idx_s1    <= rd_idx_q;
			best_slot_q   <= nxt_slot;
			best_stamp_q  <= nxt_stamp;
			best_handle_q <= nxt_handle;
		end else begin
			chk_idx_s1 <= rd_idx_q;
		end
		if (fin) begin
			res_q <= fin_res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tcklru_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tcklru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
